>>> sv/dual_moving_average_with_alarms_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual moving average block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOVING_AVERAGE_WITH_ALARMS_MACROS_SVH
`define DUAL_MOVING_AVERAGE_WITH_ALARMS_MACROS_SVH

// same-cycle implication
`define DMAA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dmaa_pkg.sv
// ----------------------------------------------------------------------------
// dmaa_pkg
// Shared types and constants of the dual moving average block.
// ----------------------------------------------------------------------------
package dmaa_pkg;

  localparam int DEFAULT_HISTORY_DEPTH = 8;

  localparam int ADC_W   = 12;
  localparam int TEMP_W  = 11;
  localparam int HUM_W   = 10;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_SOIL_DRY_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_EXTREME_LIMIT = 2'd3;

  localparam logic [ADC_W-1:0]         SOIL_DRY_LIMIT_RST      = 12'd2500;
  localparam logic [HUM_W-1:0]         HUMIDITY_LIMIT_RST      = 10'd800;
  localparam logic signed [TEMP_W-1:0] TEMPERATURE_LIMIT_RST   = 11'sd250;
  localparam logic [ADC_W-1:0]         LIGHT_EXTREME_LIMIT_RST = 12'd3500;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } dmaa_state_t;

  typedef struct packed {
    logic take;
    logic sum_en;
    logic div_start;
    logic div_step;
    logic latch;
    logic emit;
  } dmaa_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic out_free;
  } dmaa_status_t;

endpackage

>>> sv/dmaa_ctrl.sv
// ----------------------------------------------------------------------------
// dmaa_ctrl
// Sequencer: accept, sum the histories, divide, load the output register.
// ----------------------------------------------------------------------------
`include "dual_moving_average_with_alarms_macros.svh"

module dmaa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ok,
  output logic                 in_ready,
  input  dmaa_pkg::dmaa_status_t st,
  output dmaa_pkg::dmaa_cmd_t    cmd
);
  import dmaa_pkg::*;

  dmaa_state_t state;
  dmaa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_ok ? ST_SUM : ST_EMIT;
        end
      end
      ST_SUM: begin
        if (st.sum_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (st.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_SUM: begin
        cmd.sum_en    = 1'b1;
        cmd.div_start = st.sum_done;
      end
      ST_DIV: begin
        cmd.div_step = !st.div_done;
        cmd.latch    = st.div_done;
      end
      ST_EMIT: begin
        cmd.emit = st.out_free;
      end
    endcase
  end

  `DMAA_ASSERT_NOW(a_sum_not_empty, $rose(state == ST_SUM), !st.sum_done, "sum ended at once")
  `DMAA_ASSERT_NOW(a_emit_free, cmd.emit, st.out_free, "emit into a full output register")
  `DMAA_ASSERT_NEXT(a_latch_then_emit, cmd.latch, state == ST_EMIT, "latch not followed by emit")

endmodule

>>> sv/dmaa_datapath.sv
// ----------------------------------------------------------------------------
// dmaa_datapath
// History memory, accumulators, shared-divisor dividers, limits and output.
// ----------------------------------------------------------------------------
`include "dual_moving_average_with_alarms_macros.svh"

module dmaa_datapath #(
  parameter int HISTORY_DEPTH = dmaa_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dmaa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmaa_pkg::CFG_W-1:0]      cfg_data,
  input  logic [dmaa_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                            in_ok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dmaa_pkg::OUT_DATA_W-1:0] out_data,
  output logic                            out_user,
  input  dmaa_pkg::dmaa_cmd_t             cmd,
  output dmaa_pkg::dmaa_status_t          st
);
  import dmaa_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = ADC_W + $clog2(HISTORY_DEPTH);
  localparam int QW = $clog2(SW + 1);

  logic [2*ADC_W-1:0] mem [HISTORY_DEPTH];

  logic [ADC_W-1:0]         lim_soil;
  logic [HUM_W-1:0]         lim_hum;
  logic signed [TEMP_W-1:0] lim_temp;
  logic [ADC_W-1:0]         lim_light;

  logic [AW-1:0]            pos;
  logic                     full;
  logic [CW-1:0]            count;
  logic [CW-1:0]            rd_idx;
  logic                     rd_pend;
  logic [2*ADC_W-1:0]       rd_data;
  logic [SW-1:0]            acc_soil;
  logic [SW-1:0]            acc_light;
  logic [SW-1:0]            dvd_soil;
  logic [SW-1:0]            dvd_light;
  logic [CW-1:0]            rem_soil;
  logic [CW-1:0]            rem_light;
  logic [QW-1:0]            bits;

  logic signed [TEMP_W-1:0] held_temp;
  logic [HUM_W-1:0]         held_hum;
  logic [ADC_W-1:0]         held_soil;
  logic [ADC_W-1:0]         held_light;
  logic [3:0]               held_flags;
  logic                     held_valid;

  logic                     take_ok;
  logic                     more;
  logic                     issuing;
  logic [CW:0]              trial_soil;
  logic [CW:0]              trial_light;
  logic                     qbit_soil;
  logic                     qbit_light;
  logic [ADC_W-1:0]         q_soil;
  logic [ADC_W-1:0]         q_light;

  assign take_ok = cmd.take && in_ok;
  assign more    = rd_idx < count;
  assign issuing = cmd.sum_en && more;

  assign st.sum_done = !more && !rd_pend;
  assign st.div_done = bits == '0;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_soil  <= SOIL_DRY_LIMIT_RST;
      lim_hum   <= HUMIDITY_LIMIT_RST;
      lim_temp  <= TEMPERATURE_LIMIT_RST;
      lim_light <= LIGHT_EXTREME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOIL_DRY_LIMIT:      lim_soil  <= cfg_data[ADC_W-1:0];
        REG_HUMIDITY_LIMIT:      lim_hum   <= cfg_data[HUM_W-1:0];
        REG_TEMPERATURE_LIMIT:   lim_temp  <= $signed(cfg_data[TEMP_W-1:0]);
        REG_LIGHT_EXTREME_LIMIT: lim_light <= cfg_data[ADC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok) begin
      mem[pos] <= {in_data[TEMP_W+HUM_W+2*ADC_W-1:TEMP_W+HUM_W+ADC_W],
                   in_data[TEMP_W+HUM_W+ADC_W-1:TEMP_W+HUM_W]};
    end
    if (issuing) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      full    <= 1'b0;
      rd_pend <= 1'b0;
      bits    <= '0;
    end else begin
      rd_pend <= issuing;
      if (take_ok) begin
        if (pos == AW'(HISTORY_DEPTH - 1)) begin
          pos  <= '0;
          full <= 1'b1;
        end else begin
          pos <= pos + AW'(1);
        end
      end
      if (cmd.div_start) begin
        bits <= QW'(SW);
      end else if (cmd.div_step) begin
        bits <= bits - QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok) begin
      count     <= full ? CW'(HISTORY_DEPTH) : CW'(pos) + CW'(1);
      rd_idx    <= '0;
      acc_soil  <= '0;
      acc_light <= '0;
    end else begin
      if (issuing) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (rd_pend) begin
        acc_soil  <= acc_soil + SW'(rd_data[ADC_W-1:0]);
        acc_light <= acc_light + SW'(rd_data[2*ADC_W-1:ADC_W]);
      end
    end
  end

  always_comb begin
    trial_soil  = {rem_soil, dvd_soil[SW-1]};
    trial_light = {rem_light, dvd_light[SW-1]};
    qbit_soil   = trial_soil >= {1'b0, count};
    qbit_light  = trial_light >= {1'b0, count};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_soil  <= acc_soil;
      dvd_light <= acc_light;
      rem_soil  <= '0;
      rem_light <= '0;
    end else if (cmd.div_step) begin
      dvd_soil  <= {dvd_soil[SW-2:0], qbit_soil};
      dvd_light <= {dvd_light[SW-2:0], qbit_light};
      rem_soil  <= qbit_soil ? CW'(trial_soil - {1'b0, count}) : trial_soil[CW-1:0];
      rem_light <= qbit_light ? CW'(trial_light - {1'b0, count}) : trial_light[CW-1:0];
    end
  end

  assign q_soil  = dvd_soil[ADC_W-1:0];
  assign q_light = dvd_light[ADC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held_temp  <= '0;
      held_hum   <= '0;
      held_soil  <= '0;
      held_light <= '0;
      held_flags <= '0;
      held_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        held_valid <= in_ok;
      end
      if (take_ok) begin
        held_temp <= $signed(in_data[TEMP_W-1:0]);
        held_hum  <= in_data[TEMP_W+HUM_W-1:TEMP_W];
      end
      if (cmd.latch) begin
        held_soil  <= q_soil;
        held_light <= q_light;
        held_flags <= {q_light >= lim_light, held_temp > lim_temp,
                       held_hum > lim_hum, q_soil >= lim_soil};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_user <= held_valid;
      out_data <= {(OUT_DATA_W - 49)'(0), held_flags, held_light, held_soil,
                   held_hum, held_temp};
    end
  end

  `DMAA_ASSERT_NOW(a_pos_range, 1'b1, int'(pos) < HISTORY_DEPTH, "write position out of range")
  `DMAA_ASSERT_NOW(a_count_nonzero, cmd.div_start, count != '0, "divide by zero count")
  `DMAA_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "output not shown after emit")

endmodule

>>> sv/dual_moving_average_with_alarms.sv
// ----------------------------------------------------------------------------
// dual_moving_average_with_alarms
// Soil and light moving averages over a shared history, with four alarms.
// ----------------------------------------------------------------------------
// One item at a time. An item with a failed air reading skips the sums and
// the divide and goes straight to the output register. For a good item the
// history memory gives one entry per cycle to the accumulators from each of
// the N filled history entries (up to HISTORY_DEPTH), and then the divider
// resolves one quotient bit per cycle of the SW = 12 + clog2(HISTORY_DEPTH)
// bit sum. A finished result waits in the output register while the next
// item is accepted.
// ----------------------------------------------------------------------------
module dual_moving_average_with_alarms #(
  parameter int HISTORY_DEPTH = dmaa_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dmaa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmaa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // air_temperature, air_humidity, soil_sample, light_sample, zero pad
  input  logic [dmaa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // air_reading_ok
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // temperature_out, humidity_out, soil_average, light_average,
  // soil_critical, humidity_high, temperature_high, light_extreme, zero pad
  output logic [dmaa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // data_valid
  output logic                            m_axis_tuser
);
  import dmaa_pkg::*;

  dmaa_cmd_t    cmd;
  dmaa_status_t st;

  dmaa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ok    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dmaa_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_ok     (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
